/* hdl/ir8lfp_pkg.sv */
`default_nettype none

package ir8lfp_pkg;

    localparam int CHANNELS  = 8;
    localparam int FRAME_LEN = 3 + 5 * CHANNELS;

    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_D      = 8'h44;  // 'D'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_X      = 8'h78;  // 'x'
    localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE    = 8'h31;  // '1'

    localparam logic [7:0] SENSOR_RESET = 8'hFF;

    // position inside one "x<n>:<b><sep>" channel field
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_X     = 3'd0;
    localparam logic [PH_W-1:0] PH_DIGIT = 3'd1;
    localparam logic [PH_W-1:0] PH_COLON = 3'd2;
    localparam logic [PH_W-1:0] PH_BIT   = 3'd3;
    localparam logic [PH_W-1:0] PH_SEP   = 3'd4;

    localparam int CH_W = $clog2(CHANNELS);

    typedef struct packed {
        logic match;
        logic bit_en;
        logic bit_val;
    } chk_t;

    typedef struct packed {
        logic [31:0] error_frames;
        logic [31:0] bytes_seen;
        logic [31:0] good_frames;
        logic        frame_bad;
        logic        frame_ok;
        logic [7:0]  sensor_bits;
    } result_t;

endpackage

`default_nettype wire

/* hdl/ir8_line_frame_parser_unit.sv */
// Path: an accepted byte is held in the input register, then its result beat is registered onto m_tdata.
// Throughput: one byte per cycle; the input register and the result register
// both advance together, so back-to-back beats flow when m_tready stays high.
// Reset (aresetn low, synchronous): counters and frame state clear, the latched sensor_bits
// return to 0xFF, both channel valids drop; the m_tdata register itself is not reset.
`default_nettype none

module ir8_line_frame_parser_unit
    import ir8lfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] sensor_bits, [8] frame_ok, [9] frame_bad, [41:10] good_frames,
    // [73:42] bytes_seen, [105:74] error_frames, [111:106] zero
    output logic [111:0]      m_tdata
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    result;
    logic       fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    ir8lfp_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (fire),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

`default_nettype wire

/* hdl/ir8lfp_check.sv */
`default_nettype none

module ir8lfp_check
    import ir8lfp_pkg::*;
#(
    parameter int POS_W = 7
) (
    input  wire logic [POS_W-1:0] pos,
    input  wire logic [PH_W-1:0]  phase,
    input  wire logic [CH_W-1:0]  chan,
    input  wire logic [7:0]       rx_byte,
    output chk_t                  chk
);

    logic [7:0] digit;

    assign digit = CH_ONE + 8'(chan);

    always_comb begin
        chk = '0;
        if (pos == POS_W'(1)) begin
            chk.match = (rx_byte == CH_D);
        end else if (pos == POS_W'(2)) begin
            chk.match = (rx_byte == CH_COMMA);
        end else if (pos >= POS_W'(FRAME_LEN)) begin
            chk.match = 1'b0;
        end else begin
            case (phase)
                PH_X:     chk.match = (rx_byte == CH_X);
                PH_DIGIT: chk.match = (rx_byte == digit);
                PH_COLON: chk.match = (rx_byte == CH_COLON);
                PH_BIT: begin
                    chk.match   = (rx_byte == CH_ZERO) || (rx_byte == CH_ONE);
                    chk.bit_en  = chk.match;
                    chk.bit_val = rx_byte[0];
                end
                PH_SEP: begin
                    if (chan == CH_W'(CHANNELS - 1)) begin
                        chk.match = (rx_byte == CH_HASH);
                    end else begin
                        chk.match = (rx_byte == CH_COMMA);
                    end
                end
                default:  chk.match = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/ir8lfp_parser.sv */
`default_nettype none

module ir8lfp_parser
    import ir8lfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    output result_t         result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic              in_frame_reg,  in_frame_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [PH_W-1:0]   phase_reg,     phase_next;
    logic [CH_W-1:0]   chan_reg,      chan_next;
    logic              valid_reg,     valid_next;
    logic [7:0]        partial_reg,   partial_next;
    logic [7:0]        latched_reg,   latched_next;
    logic [31:0]       ok_cnt_reg,    ok_cnt_next;
    logic [31:0]       byte_cnt_reg,  byte_cnt_next;
    logic [31:0]       err_cnt_reg,   err_cnt_next;
    logic              ok_flag, bad_flag;
    chk_t              chk;

    ir8lfp_check #(
        .POS_W (POS_W)
    ) u_check (
        .pos     (pos_reg),
        .phase   (phase_reg),
        .chan    (chan_reg),
        .rx_byte (rx_byte),
        .chk     (chk)
    );

    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        chan_next     = chan_reg;
        valid_next    = valid_reg;
        partial_next  = partial_reg;
        latched_next  = latched_reg;
        ok_cnt_next   = ok_cnt_reg;
        byte_cnt_next = byte_cnt_reg + 32'd1;
        err_cnt_next  = err_cnt_reg;
        ok_flag       = 1'b0;
        bad_flag      = 1'b0;

        if (rx_byte == CH_DOLLAR) begin
            in_frame_next = 1'b1;
            pos_next      = POS_W'(1);
            phase_next    = PH_X;
            chan_next     = '0;
            valid_next    = 1'b1;
            partial_next  = '0;
        end else if (in_frame_reg) begin
            if (pos_reg >= POS_W'(MAX_FRAME_BYTES)) begin
                // overlong: byte is not examined
                in_frame_next = 1'b0;
                pos_next      = '0;
                err_cnt_next  = err_cnt_reg + 32'd1;
                bad_flag      = 1'b1;
            end else begin
                pos_next   = pos_reg + POS_W'(1);
                valid_next = valid_reg & chk.match;
                if (chk.bit_en) begin
                    partial_next = {partial_reg[6:0], chk.bit_val};
                end
                if (pos_reg >= POS_W'(3) && pos_reg < POS_W'(FRAME_LEN)) begin
                    if (phase_reg == PH_SEP) begin
                        phase_next = PH_X;
                        chan_next  = chan_reg + CH_W'(1);
                    end else begin
                        phase_next = phase_reg + PH_W'(1);
                    end
                end
                if (rx_byte == CH_HASH) begin
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                    if (valid_next && pos_reg == POS_W'(FRAME_LEN - 1)) begin
                        latched_next = partial_next;
                        ok_cnt_next  = ok_cnt_reg + 32'd1;
                        ok_flag      = 1'b1;
                    end else begin
                        err_cnt_next = err_cnt_reg + 32'd1;
                        bad_flag     = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        result.sensor_bits  = latched_next;
        result.frame_ok     = ok_flag;
        result.frame_bad    = bad_flag;
        result.good_frames  = ok_cnt_next;
        result.bytes_seen   = byte_cnt_next;
        result.error_frames = err_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            phase_reg    <= PH_X;
            chan_reg     <= '0;
            valid_reg    <= 1'b1;
            partial_reg  <= '0;
            latched_reg  <= SENSOR_RESET;
            ok_cnt_reg   <= '0;
            byte_cnt_reg <= '0;
            err_cnt_reg  <= '0;
        end else if (advance) begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            chan_reg     <= chan_next;
            valid_reg    <= valid_next;
            partial_reg  <= partial_next;
            latched_reg  <= latched_next;
            ok_cnt_reg   <= ok_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            err_cnt_reg  <= err_cnt_next;
        end
    end

endmodule

`default_nettype wire
